>>> rtl/stfc_pkg.sv
package stfc_pkg;

  // Field widths
  localparam int unsigned FrameLenW = 9;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned CntW      = 32;

  // Frame format
  localparam int unsigned          DefMaxFrameBytes = 256;
  localparam int unsigned          MinFrameBytes    = 4;
  localparam logic [FrameLenW-1:0] FrameLenReset    = 9'd64;
  localparam logic [CrcW-1:0]      CrcInit          = 16'hFFFF;
  localparam logic [ByteW-1:0]     MarkerA          = 8'd3;
  localparam logic [ByteW-1:0]     MarkerB          = 8'd4;
  localparam int unsigned          MarkerPosA       = 2;
  localparam int unsigned          MarkerPosB       = 3;

  // One verdict, as handed to the result ports
  typedef struct packed {
    logic            frame_good;
    logic            marker_ok;
    logic [CrcW-1:0] crc_residue;
    logic [CntW-1:0] good_frames;
    logic [CntW-1:0] bad_frames;
    logic [CntW-1:0] next_frame_number;
  } stfc_result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first (poly 0x1021)
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0]  crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] x;
    logic [CrcW-1:0]  x16;
    x   = crc[15:8] ^ b;
    x   = x ^ (x >> 4);
    x16 = {8'h00, x};
    return {crc[7:0], 8'h00} ^ (x16 << 12) ^ (x16 << 5) ^ x16;
  endfunction

endpackage

>>> rtl/stfc_in_reg.sv
module stfc_in_reg
  import stfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_byte_valid_i,
  output logic             rx_byte_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             byte_valid_o,
  output logic [ByteW-1:0] byte_o,
  input  logic             byte_take_i
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  // Slot is free when empty or being drained this cycle
  assign rx_byte_ready_o = !valid_q || byte_take_i;

  always_comb begin
    valid_d = valid_q;
    if (rx_byte_ready_o) begin
      valid_d = rx_byte_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (rx_byte_ready_o && rx_byte_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

>>> rtl/stfc_verdict.sv
module stfc_verdict
  import stfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [FrameLenW-1:0] frame_length_i,
  input  logic                 byte_valid_i,
  input  logic [ByteW-1:0]     byte_i,
  output logic                 byte_take_o,
  output logic                 result_valid_o,
  input  logic                 result_ready_i,
  output stfc_result_t         result_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned LenW = ($clog2(MAX_FRAME_BYTES + 1) > FrameLenW) ?
                                 $clog2(MAX_FRAME_BYTES + 1) : FrameLenW;
  localparam logic [LenW-1:0] LenMin = LenW'(MinFrameBytes);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_FRAME_BYTES);

  logic [CrcW-1:0] crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            mark_q, mark_d;
  logic [CntW-1:0] good_q, good_d;
  logic [CntW-1:0] bad_q, bad_d;
  logic [CntW-1:0] fnum_q, fnum_d;
  logic            out_valid_q, out_valid_d;
  stfc_result_t    out_q, out_d;

  logic [LenW-1:0] len_cfg, len_eff, pos_next;
  logic [CrcW-1:0] crc_new;
  logic            mark_new, last_byte, good;

  // Take the byte when the result slot is free or drains now
  assign byte_take_o = byte_valid_i && (!out_valid_q || result_ready_i);

  // Clamp the configured length
  always_comb begin
    len_cfg = LenW'(frame_length_i);
    len_eff = len_cfg;
    if (len_cfg < LenMin) begin
      len_eff = LenMin;
    end else if (len_cfg > LenMax) begin
      len_eff = LenMax;
    end
  end

  // Per-byte check
  always_comb begin
    crc_new  = crc_update(crc_q, byte_i);
    mark_new = mark_q;
    if (pos_q == PosW'(MarkerPosA) && byte_i != MarkerA) begin
      mark_new = 1'b0;
    end
    if (pos_q == PosW'(MarkerPosB) && byte_i != MarkerB) begin
      mark_new = 1'b0;
    end
    pos_next  = LenW'(pos_q) + LenW'(1);
    last_byte = (pos_next >= len_eff);
    good      = mark_new && (crc_new == '0);
  end

  // State and result update
  always_comb begin
    crc_d       = crc_q;
    pos_d       = pos_q;
    mark_d      = mark_q;
    good_d      = good_q;
    bad_d       = bad_q;
    fnum_d      = fnum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_ready_i;
    if (byte_take_o) begin
      if (last_byte) begin
        crc_d  = CrcInit;
        pos_d  = '0;
        mark_d = 1'b1;
        if (good) begin
          good_d = good_q + CntW'(1);
          fnum_d = fnum_q + CntW'(1);
        end else begin
          bad_d = bad_q + CntW'(1);
        end
        out_valid_d             = 1'b1;
        out_d.frame_good        = good;
        out_d.marker_ok         = mark_new;
        out_d.crc_residue       = crc_new;
        out_d.good_frames       = good_d;
        out_d.bad_frames        = bad_d;
        out_d.next_frame_number = fnum_d;
      end else begin
        crc_d  = crc_new;
        pos_d  = pos_next[PosW-1:0];
        mark_d = mark_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      pos_q       <= '0;
      mark_q      <= 1'b1;
      good_q      <= '0;
      bad_q       <= '0;
      fnum_q      <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      pos_q       <= pos_d;
      mark_q      <= mark_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      fnum_q      <= fnum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

>>> rtl/spi_test_frame_checker_core.sv
// Channel   Direction  Handshake                          Payload
// cfg       in         cfg_we_i (no wait)                 cfg_wdata_i = frame_length
// rx_byte   in         rx_byte_valid_i / rx_byte_ready_o  rx_byte_i
// result    out        result_valid_o / result_ready_i    frame_good_o .. next_frame_number_o
//
// One byte per cycle sustained. A byte waits in the input register, and
// while it waits the CRC, marker and counter update runs into the result
// register, so a verdict is registered once the last byte of a frame has
// left the input register. While a verdict waits on result_ready_i, one
// more byte is held at the input and further bytes stall. Reset is asynchronous,
// active low, and restores frame_length 64 and the counters; no clearing pass.
module spi_test_frame_checker_core
  import stfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [FrameLenW-1:0] cfg_wdata_i,
  input  logic                 rx_byte_valid_i,
  output logic                 rx_byte_ready_o,
  input  logic [ByteW-1:0]     rx_byte_i,
  output logic                 result_valid_o,
  input  logic                 result_ready_i,
  output logic                 frame_good_o,
  output logic                 marker_ok_o,
  output logic [CrcW-1:0]      crc_residue_o,
  output logic [CntW-1:0]      good_frames_o,
  output logic [CntW-1:0]      bad_frames_o,
  output logic [CntW-1:0]      next_frame_number_o
);

  logic [FrameLenW-1:0] frame_length_q;
  logic                 byte_valid, byte_take;
  logic [ByteW-1:0]     byte_q;
  stfc_result_t         result;

  // Frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= FrameLenReset;
    end else if (cfg_we_i) begin
      frame_length_q <= cfg_wdata_i;
    end
  end

  stfc_in_reg u_in_reg (
    .clk_i,
    .rst_ni,
    .rx_byte_valid_i,
    .rx_byte_ready_o,
    .rx_byte_i,
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q),
    .byte_take_i  (byte_take)
  );

  stfc_verdict #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_verdict (
    .clk_i,
    .rst_ni,
    .frame_length_i (frame_length_q),
    .byte_valid_i   (byte_valid),
    .byte_i         (byte_q),
    .byte_take_o    (byte_take),
    .result_valid_o,
    .result_ready_i,
    .result_o       (result)
  );

  assign frame_good_o        = result.frame_good;
  assign marker_ok_o         = result.marker_ok;
  assign crc_residue_o       = result.crc_residue;
  assign good_frames_o       = result.good_frames;
  assign bad_frames_o        = result.bad_frames;
  assign next_frame_number_o = result.next_frame_number;

endmodule

>>> verif/spi_test_frame_checker_core_tb.sv
`timescale 1ns / 100ps

module spi_test_frame_checker_core_tb;
  import stfc_pkg::*;

  localparam int unsigned ClkPeriod = 12;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t byteq_t[$];

  // Kinds of frames the generator builds
  typedef enum int unsigned {
    FrmGood,
    FrmBadMarker,
    FrmBadCrc,
    FrmNoise
  } frame_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [FrameLenW-1:0] cfg_wdata_i = '0;
  logic rx_byte_valid_i = 1'b0;
  logic rx_byte_ready_o;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic result_valid_o;
  logic result_ready_i = 1'b0;
  logic frame_good_o;
  logic marker_ok_o;
  logic [CrcW-1:0] crc_residue_o;
  logic [CntW-1:0] good_frames_o;
  logic [CntW-1:0] bad_frames_o;
  logic [CntW-1:0] next_frame_number_o;

  spi_test_frame_checker_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .rx_byte_valid_i    (rx_byte_valid_i),
    .rx_byte_ready_o    (rx_byte_ready_o),
    .rx_byte_i          (rx_byte_i),
    .result_valid_o     (result_valid_o),
    .result_ready_i     (result_ready_i),
    .frame_good_o       (frame_good_o),
    .marker_ok_o        (marker_ok_o),
    .crc_residue_o      (crc_residue_o),
    .good_frames_o      (good_frames_o),
    .bad_frames_o       (bad_frames_o),
    .next_frame_number_o(next_frame_number_o)
  );

  // Bytes waiting to be offered, verdicts waiting to come out
  byte_t        byte_q[$];
  stfc_result_t verdict_q[$];

  // Frame checker state as the block should hold it
  logic [FrameLenW-1:0] len_cfg    = FrameLenReset;
  logic [CrcW-1:0]      run_crc    = CrcInit;
  int unsigned          frame_pos  = 0;
  logic                 markers_ok = 1'b1;
  logic [CntW-1:0]      n_good     = '0;
  logic [CntW-1:0]      n_bad      = '0;
  logic [CntW-1:0]      next_num   = 1;

  int unsigned errors = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned in_stalls = 0;
  int unsigned tail_pos = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // Clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Random idling, with no idling in the first quarter of each period
  function automatic int unsigned idle_pct();
    return ((($time / ClkPeriod) % 4000) < 1000) ? 0 : 24;
  endfunction

  // CRC-16, polynomial 0x1021, MSB first, bit by bit
  function automatic logic [CrcW-1:0] crc16_step(input logic [CrcW-1:0] c, input byte_t b);
    logic [CrcW-1:0] v;
    v = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      v = v[15] ? ((v << 1) ^ CrcPoly) : (v << 1);
    end
    return v;
  endfunction

  // Frame length in use: register value clamped to the legal range
  function automatic int unsigned eff_len(input logic [FrameLenW-1:0] l);
    if (l < MinFrameBytes) return MinFrameBytes;
    if (l > DefMaxFrameBytes) return DefMaxFrameBytes;
    return l;
  endfunction

  // Advance the frame checker by one byte, queue a verdict at frame end
  task automatic predict_byte(input byte_t b);
    stfc_result_t r;
    logic         good;
    run_crc = crc16_step(run_crc, b);
    if (frame_pos == MarkerPosA && b != MarkerA) markers_ok = 1'b0;
    if (frame_pos == MarkerPosB && b != MarkerB) markers_ok = 1'b0;
    if (frame_pos + 1 < eff_len(len_cfg)) begin
      frame_pos++;
    end else begin
      good = markers_ok && (run_crc == '0);
      if (good) begin
        n_good++;
        next_num++;
      end else begin
        n_bad++;
      end
      r.frame_good        = good;
      r.marker_ok         = markers_ok;
      r.crc_residue       = run_crc;
      r.good_frames       = n_good;
      r.bad_frames        = n_bad;
      r.next_frame_number = next_num;
      verdict_q.push_back(r);
      run_crc    = CrcInit;
      frame_pos  = 0;
      markers_ok = 1'b1;
    end
  endtask

  function automatic byteq_t sealed(input byteq_t f);
    logic [CrcW-1:0] c;
    byteq_t          r;
    c = CrcInit;
    r = f;
    foreach (f[i]) c = crc16_step(c, f[i]);
    r.push_back(c[15:8]);
    r.push_back(c[7:0]);
    return r;
  endfunction

  task automatic send_raw(input byteq_t f);
    foreach (f[i]) byte_q.push_back(f[i]);
    bytes_queued += f.size();
  endtask

  task automatic send_random(input int unsigned n);
    byteq_t f;
    f = {};
    repeat (n) f.push_back(byte_t'($urandom_range(255)));
    send_raw(f);
  endtask

  // Build one frame of the given kind and length
  task automatic queue_frame(input frame_kind_e kind, input int unsigned len);
    byteq_t      frm;
    int unsigned pos;
    frm = {};
    if (kind == FrmNoise) begin
      send_random(len);
    end else begin
      repeat (len - 2) frm.push_back(byte_t'($urandom_range(255)));
      if (len - 2 > MarkerPosA) frm[MarkerPosA] = MarkerA;
      if (len - 2 > MarkerPosB) frm[MarkerPosB] = MarkerB;
      if (kind == FrmBadMarker && len - 2 > MarkerPosA) begin
        pos = (len - 2 > MarkerPosB) ? $urandom_range(MarkerPosB, MarkerPosA) : MarkerPosA;
        frm[pos] = frm[pos] ^ byte_t'($urandom_range(255, 1));
      end
      frm = sealed(frm);
      if (kind == FrmBadCrc) begin
        pos = $urandom_range(len - 1);
        frm[pos] = frm[pos] ^ byte_t'(1 << $urandom_range(7));
      end
      send_raw(frm);
    end
  endtask

  // Wait until every byte is in and every verdict out, plus pipeline drain
  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || rx_byte_valid_i || verdict_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [FrameLenW-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_cfg = v;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // One setting: finish any open frame, a run of frames, maybe a partial tail
  task automatic run_phase(input logic [FrameLenW-1:0] cfg, input int unsigned n_frames);
    int unsigned len;
    int unsigned pick;
    set_length(cfg);
    len = eff_len(cfg);
    if (tail_pos != 0) begin
      send_random((tail_pos >= len) ? 1 : len - tail_pos);
      tail_pos = 0;
    end
    repeat (n_frames) begin
      pick = $urandom_range(99);
      if (pick < 60) queue_frame(FrmGood, len);
      else if (pick < 75) queue_frame(FrmBadMarker, len);
      else if (pick < 90) queue_frame(FrmBadCrc, len);
      else queue_frame(FrmNoise, len);
    end
    if ($urandom_range(1) == 1) begin
      tail_pos = $urandom_range(1, (len - 1 > 12) ? 12 : len - 1);
      send_random(tail_pos);
    end
  endtask

  // Stimulus
  initial begin
    byteq_t      f;
    int unsigned pick;
    logic [FrameLenW-1:0] cfg;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, marker-only frame, sealed short frames (the last one good)
    set_length(FrameLenW'(4));
    f = {8'h00, 8'h00, 8'h00, 8'h00};
    send_raw(f);
    f = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_raw(f);
    f = {8'h00, 8'h00, MarkerA, MarkerB};
    send_raw(f);
    f = {8'hFF, 8'h00};
    send_raw(sealed(f));
    set_length(FrameLenW'(6));
    f = {8'hFF, 8'h00, MarkerA, MarkerB};
    send_raw(sealed(f));

    // Clamp at both ends, full-size frames, reset length
    run_phase(FrameLenW'(0), 30);
    run_phase(FrameLenW'(511), 1);
    run_phase(FrameLenW'(3), 15);
    run_phase(FrameLenW'(256), 1);
    run_phase(FrameLenW'(64), 2);

    // Random settings, mostly short frames
    while (bytes_queued < 1620) begin
      pick = $urandom_range(99);
      if (pick < 10) cfg = FrameLenW'($urandom_range(3));
      else if (pick < 20) cfg = FrameLenW'($urandom_range(80, 25));
      else cfg = FrameLenW'($urandom_range(24, 4));
      run_phase(cfg, $urandom_range(10, 2));
    end

    wait_idle();
    $display("Checked %0d verdicts (%0d good) from %0d bytes across %0d length writes;",
             verdicts_seen, n_good, bytes_taken, cfg_writes);
    $display("input held off for %0d cycles by back-pressure.", in_stalls);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Driver: offers queued bytes, predicts each accepted request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_byte_valid_i <= 1'b0;
    end else begin
      if (rx_byte_valid_i && rx_byte_ready_o) begin
        predict_byte(rx_byte_i);
        bytes_taken++;
      end else if (rx_byte_valid_i) begin
        in_stalls++;
      end
      if (!rx_byte_valid_i || rx_byte_ready_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          rx_byte_valid_i <= 1'b1;
          rx_byte_i       <= byte_q.pop_front();
        end else begin
          rx_byte_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready, plus one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready_i <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (!hold_done && verdicts_seen >= 30) begin
      result_ready_i <= 1'b0;
      hold_left      <= 200;
      hold_done      <= 1'b1;
    end else begin
      result_ready_i <= ($urandom_range(99) >= idle_pct());
    end
  end

  function automatic void check_field(input string name, input logic [CntW-1:0] want,
                                      input logic [CntW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // Monitor: compare each accepted verdict with the oldest expected one
  always @(posedge clk_i) begin
    stfc_result_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict, expected none got crc %h", $time, crc_residue_o);
      end else begin
        want = verdict_q.pop_front();
        check_field("frame_good", CntW'(want.frame_good), CntW'(frame_good_o));
        check_field("marker_ok", CntW'(want.marker_ok), CntW'(marker_ok_o));
        check_field("crc_residue", CntW'(want.crc_residue), CntW'(crc_residue_o));
        check_field("good_frames", want.good_frames, good_frames_o);
        check_field("bad_frames", want.bad_frames, bad_frames_o);
        check_field("next_frame_number", want.next_frame_number, next_frame_number_o);
      end
    end
  end

  // Watchdog
  initial begin
    #(ClkPeriod * 300000);
    $display("Timed out with %0d verdicts outstanding", verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> spi_test_frame_checker_core.f
rtl/stfc_pkg.sv
rtl/stfc_in_reg.sv
rtl/stfc_verdict.sv
rtl/spi_test_frame_checker_core.sv
verif/spi_test_frame_checker_core_tb.sv
